### rtl/pmma_pkg.sv
// ============================================================================
// pmma_pkg
// Shared types and constants for the paged memory allocator.
// ============================================================================
package pmma_pkg;

    localparam int SIZE_W   = 21;
    localparam int VA_W     = 20;
    localparam int PID_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 32;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic scan_rst;
        logic scan_run;
        logic cnt_free;
        logic take;
        logic look;
        logic base_ld;
        logic brk_alloc;
        logic free_wr;
        logic free_nx;
        logic free_adv;
        logic brk_tgt;
        logic brk_dec;
        logic ram_acc;
        logic rsp_set;
        logic rsp_ok;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode op;
        logic    pid_ok;
        logic    pages_zero;
        logic    dvld;
        logic    dlast;
        logic    match;
        logic    enough;
        logic    fits;
        logic    take_done;
        logic    is_last;
        logic    nx_ok;
        logic    chain_ok;
        logic    end_at_brk;
        logic    brk_ge2;
        logic    clr_done;
    } t_dp_sts;

endpackage

### rtl/pmma_ram.sv
// ============================================================================
// pmma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module pmma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pmma_datapath.sv
// ============================================================================
// pmma_datapath
// Page store RAMs, byte RAM, break registers, scan pointer and result word.
// ============================================================================
module pmma_datapath import pmma_pkg::*; #(
    parameter int OFFSET_BITS    = 10,
    parameter int ADDRESS_BITS   = 20,
    parameter int NUM_PHYS_PAGES = 1024,
    parameter int MAX_PROCS      = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_in_data,
    output logic [OUT_W-1:0]  o_out_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts
);

    localparam int PGW = $clog2(NUM_PHYS_PAGES);
    localparam int VPW = ADDRESS_BITS - OFFSET_BITS;
    localparam int PW  = SIZE_W + 1 - OFFSET_BITS;
    localparam int RAW = PGW + OFFSET_BITS;
    localparam int SW  = (VPW > PW ? VPW : PW) + 1;
    localparam int EW  = (VPW > PGW + 1 ? VPW : PGW + 1) + 1;
    localparam int PXW = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
    localparam logic [RAW:0] CLR_END = (RAW+1)'(NUM_PHYS_PAGES) << OFFSET_BITS;
    localparam logic [PGW:0] NPG     = (PGW+1)'(NUM_PHYS_PAGES);

    // input word fields
    logic [1:0]          in_op;
    logic [PID_W-1:0]    in_pid;
    logic [SIZE_W-1:0]   in_size;
    logic [31:0]         in_va;
    logic [BYTE_W-1:0]   in_wb;
    logic [SIZE_W:0]     size_rnd;

    assign in_op    = i_in_data[1:0];
    assign in_pid   = i_in_data[5:2];
    assign in_size  = i_in_data[26:6];
    assign in_va    = {12'd0, i_in_data[46:27]};
    assign in_wb    = i_in_data[54:47];
    assign size_rnd = {1'b0, in_size} + (SIZE_W+1)'((1 << OFFSET_BITS) - 1);

    // command registers
    t_opcode              r_op;
    logic [PID_W-1:0]     r_pid;
    logic [VPW-1:0]       r_tvpn;
    logic [OFFSET_BITS-1:0] r_off;
    logic [BYTE_W-1:0]    r_wb;
    logic [PW-1:0]        r_pages;
    logic [PGW:0]         r_free_cnt;
    logic [PW-1:0]        r_done;
    logic [PGW:0]         r_fcount;
    logic [VPW-1:0]       r_base;
    logic [PGW-1:0]       r_prev;
    logic [PGW-1:0]       r_cur;
    logic [VPW-1:0]       r_cur_vpn;
    logic [VPW-1:0]       r_brk [MAX_PROCS];
    logic [PGW:0]         r_idx;
    logic                 r_dvld;
    logic [PGW-1:0]       r_didx;
    logic [RAW-1:0]       r_clr;
    logic [OUT_W-1:0]     r_out;

    logic [PXW-1:0]       pidx;
    logic [VPW-1:0]       brk_cur;
    logic [PID_W-1:0]     owner_rd;
    logic [VPW-1:0]       vpn_rd;
    logic [PGW-1:0]       next_rd;
    logic                 last_rd;
    logic [BYTE_W-1:0]    byte_rd;
    logic                 owner_free;
    logic                 take_done;
    logic                 take_fire;
    logic [SW-1:0]        fit_sum;
    logic [SW-1:0]        take_vpn;
    logic [EW-1:0]        end_vpn;
    logic [PGW-1:0]       own_raddr;
    logic                 own_we;
    logic [PGW-1:0]       own_waddr;
    logic [PID_W-1:0]     own_wdata;
    logic [RAW-1:0]       phys_addr;
    logic [31:0]          alloc_addr;

    assign pidx       = PXW'(r_pid - 4'd1);
    assign brk_cur    = r_brk[pidx];
    assign owner_free = (owner_rd == '0);
    assign take_done  = (r_done == r_pages);
    assign take_fire  = i_cmd.take && r_dvld && owner_free && !take_done;
    assign fit_sum    = SW'(brk_cur) + SW'(r_pages);
    assign take_vpn   = SW'(r_base) + SW'(r_done);
    assign end_vpn    = EW'(r_tvpn) + EW'(r_fcount);
    assign own_raddr  = i_cmd.free_nx ? next_rd : r_idx[PGW-1:0];
    assign phys_addr  = {r_cur, r_off};
    assign alloc_addr = 32'(r_base) << OFFSET_BITS;

    always_comb begin
        own_we    = 1'b0;
        own_waddr = r_cur;
        own_wdata = '0;
        if (i_cmd.clr) begin
            own_we    = 1'b1;
            own_waddr = r_clr[RAW-1:OFFSET_BITS];
        end else if (take_fire) begin
            own_we    = 1'b1;
            own_waddr = r_didx;
            own_wdata = r_pid;
        end else if (i_cmd.free_wr) begin
            own_we    = 1'b1;
        end
    end

    pmma_ram #(.WIDTH(PID_W), .DEPTH(NUM_PHYS_PAGES)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_waddr), .i_wdata(own_wdata),
        .i_re(1'b1), .i_raddr(own_raddr), .o_rdata(owner_rd)
    );

    pmma_ram #(.WIDTH(VPW), .DEPTH(NUM_PHYS_PAGES)) u_vpn (
        .i_clk(i_clk), .i_we(take_fire), .i_waddr(r_didx),
        .i_wdata(take_vpn[VPW-1:0]),
        .i_re(1'b1), .i_raddr(own_raddr), .o_rdata(vpn_rd)
    );

    pmma_ram #(.WIDTH(PGW), .DEPTH(NUM_PHYS_PAGES)) u_next (
        .i_clk(i_clk), .i_we(take_fire && (r_done != '0)), .i_waddr(r_prev),
        .i_wdata(r_didx),
        .i_re(1'b1), .i_raddr(r_cur), .o_rdata(next_rd)
    );

    pmma_ram #(.WIDTH(1), .DEPTH(NUM_PHYS_PAGES)) u_last (
        .i_clk(i_clk), .i_we(take_fire), .i_waddr(r_didx),
        .i_wdata(r_done + PW'(1) == r_pages),
        .i_re(1'b1), .i_raddr(r_cur), .o_rdata(last_rd)
    );

    pmma_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_PHYS_PAGES << OFFSET_BITS)) u_bytes (
        .i_clk(i_clk),
        .i_we(i_cmd.clr || (i_cmd.ram_acc && r_op == OP_WRITE)),
        .i_waddr(i_cmd.clr ? r_clr : phys_addr),
        .i_wdata(i_cmd.clr ? '0 : r_wb),
        .i_re(i_cmd.ram_acc && r_op == OP_READ),
        .i_raddr(phys_addr), .o_rdata(byte_rd)
    );

    // clear sweep counter and per-process breaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                r_brk[i] <= VPW'(1);
            end
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + RAW'(1);
            end
            if (i_cmd.brk_alloc) begin
                r_brk[pidx] <= fit_sum[VPW-1:0];
            end else if (i_cmd.brk_dec) begin
                r_brk[pidx] <= brk_cur - VPW'(1);
            end
        end
    end

    // scan pointer: address issued at r_idx, data tagged in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_dvld <= 1'b0;
        end else if (i_cmd.load || i_cmd.scan_rst) begin
            r_idx  <= '0;
            r_dvld <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_dvld <= (r_idx < NPG);
            if (r_idx < NPG) begin
                r_idx <= r_idx + (PGW+1)'(1);
            end
        end else begin
            r_dvld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_idx[PGW-1:0];
        if (i_cmd.load) begin
            r_op       <= t_opcode'(in_op);
            r_pid      <= in_pid;
            r_tvpn     <= in_va[ADDRESS_BITS-1:OFFSET_BITS];
            r_off      <= in_va[OFFSET_BITS-1:0];
            r_wb       <= in_wb;
            r_pages    <= size_rnd[SIZE_W:OFFSET_BITS];
            r_free_cnt <= '0;
            r_done     <= '0;
            r_fcount   <= '0;
        end
        if (i_cmd.cnt_free && r_dvld && owner_free) begin
            r_free_cnt <= r_free_cnt + (PGW+1)'(1);
        end
        if (i_cmd.base_ld) begin
            r_base <= brk_cur;
        end
        if (take_fire) begin
            r_prev <= r_didx;
            r_done <= r_done + PW'(1);
        end
        if (i_cmd.look && r_dvld && o_sts.match) begin
            r_cur     <= r_didx;
            r_cur_vpn <= r_tvpn;
        end
        if (i_cmd.free_wr) begin
            r_fcount <= r_fcount + (PGW+1)'(1);
        end
        if (i_cmd.free_adv) begin
            r_cur     <= next_rd;
            r_cur_vpn <= r_cur_vpn + VPW'(1);
        end
        if (i_cmd.brk_tgt) begin
            r_tvpn <= brk_cur - VPW'(1);
        end
        if (i_cmd.rsp_set) begin
            r_out[19:0]  <= (i_cmd.rsp_ok && r_op == OP_ALLOC) ? alloc_addr[19:0] : '0;
            r_out[27:20] <= (i_cmd.rsp_ok && r_op == OP_READ) ? byte_rd : '0;
            r_out[28]    <= !i_cmd.rsp_ok;
            r_out[31:29] <= '0;
        end
    end

    assign o_out_data = r_out;

    assign o_sts.op         = r_op;
    assign o_sts.pid_ok     = (r_pid != '0) && (32'(r_pid) <= MAX_PROCS);
    assign o_sts.pages_zero = (r_pages == '0);
    assign o_sts.dvld       = r_dvld;
    assign o_sts.dlast      = (r_didx == PGW'(NUM_PHYS_PAGES - 1));
    assign o_sts.match      = (owner_rd == r_pid) && (vpn_rd == r_tvpn);
    assign o_sts.enough     = ((PW+PGW+1)'(r_free_cnt) >= (PW+PGW+1)'(r_pages));
    assign o_sts.fits       = ((fit_sum >> VPW) == '0);
    assign o_sts.take_done  = take_done;
    assign o_sts.is_last    = last_rd;
    assign o_sts.nx_ok      = ({1'b0, next_rd} < NPG);
    assign o_sts.chain_ok   = (owner_rd == r_pid) &&
                              ({1'b0, vpn_rd} == {1'b0, r_cur_vpn} + (VPW+1)'(1));
    assign o_sts.end_at_brk = (end_vpn == EW'(brk_cur));
    assign o_sts.brk_ge2    = (brk_cur >= VPW'(2));
    assign o_sts.clr_done   = ({1'b0, r_clr} == CLR_END - (RAW+1)'(1));

    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_fire |-> (r_done < r_pages))
        else $error("page taken past request");

endmodule

### rtl/pmma_ctrl.sv
// ============================================================================
// pmma_ctrl
// Command sequencer: scans, chain walk, break lowering, result handoff.
// ============================================================================
module pmma_ctrl import pmma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [14:0] {
        ST_CLEAR = 15'b000000000000001,
        ST_IDLE  = 15'b000000000000010,
        ST_DISP  = 15'b000000000000100,
        ST_ACNT  = 15'b000000000001000,
        ST_ACHK  = 15'b000000000010000,
        ST_ATAKE = 15'b000000000100000,
        ST_LOOK  = 15'b000000001000000,
        ST_FWR   = 15'b000000010000000,
        ST_FCK1  = 15'b000000100000000,
        ST_FCK2  = 15'b000001000000000,
        ST_BCHK  = 15'b000010000000000,
        ST_BLOOP = 15'b000100000000000,
        ST_BSCAN = 15'b001000000000000,
        ST_RWACC = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state    = r_state;
        n_ok       = r_ok;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                n_ok = 1'b0;
                if (!i_sts.pid_ok) begin
                    n_state = ST_DONE;
                end else if (i_sts.op == OP_ALLOC) begin
                    n_state = i_sts.pages_zero ? ST_DONE : ST_ACNT;
                end else begin
                    n_state = ST_LOOK;
                end
            end
            ST_ACNT: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.cnt_free = 1'b1;
                if (i_sts.dvld && i_sts.dlast) n_state = ST_ACHK;
            end
            ST_ACHK: begin
                if (i_sts.enough && i_sts.fits) begin
                    o_cmd.scan_rst = 1'b1;
                    o_cmd.base_ld  = 1'b1;
                    n_state        = ST_ATAKE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ATAKE: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.take     = 1'b1;
                if (i_sts.take_done) begin
                    o_cmd.brk_alloc = 1'b1;
                    n_ok            = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_LOOK: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.look     = 1'b1;
                if (i_sts.dvld && i_sts.match) begin
                    n_state = (i_sts.op == OP_FREE) ? ST_FWR : ST_RWACC;
                end else if (i_sts.dvld && i_sts.dlast) begin
                    n_state = ST_DONE;
                end
            end
            ST_FWR: begin
                o_cmd.free_wr = 1'b1;
                n_state       = ST_FCK1;
            end
            ST_FCK1: begin
                if (i_sts.is_last || !i_sts.nx_ok) begin
                    n_state = ST_BCHK;
                end else begin
                    o_cmd.free_nx = 1'b1;
                    n_state       = ST_FCK2;
                end
            end
            ST_FCK2: begin
                if (i_sts.chain_ok) begin
                    o_cmd.free_adv = 1'b1;
                    n_state        = ST_FWR;
                end else begin
                    n_state = ST_BCHK;
                end
            end
            ST_BCHK: begin
                n_ok    = 1'b1;
                n_state = i_sts.end_at_brk ? ST_BLOOP : ST_DONE;
            end
            ST_BLOOP: begin
                if (i_sts.brk_ge2) begin
                    o_cmd.brk_tgt  = 1'b1;
                    o_cmd.scan_rst = 1'b1;
                    n_state        = ST_BSCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_BSCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.dvld && i_sts.match) begin
                    n_state = ST_DONE;
                end else if (i_sts.dvld && i_sts.dlast) begin
                    o_cmd.brk_dec = 1'b1;
                    n_state       = ST_BLOOP;
                end
            end
            ST_RWACC: begin
                o_cmd.ram_acc = 1'b1;
                n_ok          = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.rsp_set = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.rsp_ok = r_ok;
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        if (o_cmd.rsp_set)           n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ok     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ok     <= n_ok;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DISP))
        else $error("accepted word not dispatched");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside done");

endmodule

### rtl/paged_memory_allocator_mmu_top.sv
// ============================================================================
// paged_memory_allocator_mmu_top
// Paged allocator with per-process virtual spaces over a byte RAM.
// ============================================================================
// Bad pid goes straight to the result; read/write/free first scan the owner/vpn
// store for the matching page, the store read one entry a cycle.
// Allocate: two passes over the owner store, a count of free pages, then the take.
// Free: lookup, then a walk of the page chain, then a rescan per page the break drops.
// Throughput: one word in flight; the result register frees the input side.
// Reset: sync active low, then a clear sweep over the byte RAM and owner store.
module paged_memory_allocator_mmu_top import pmma_pkg::*; #(
    parameter int OFFSET_BITS    = 10,
    parameter int ADDRESS_BITS   = 20,
    parameter int NUM_PHYS_PAGES = 1024,
    parameter int MAX_PROCS      = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] opcode, [5:2] pid, [26:6] size_bytes, [46:27] virt_address,
    // [54:47] write_byte, [55] zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [19:0] alloc_address, [27:20] read_byte, [28] status, [31:29] zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: one-hot FSM, drives the handshakes
    pmma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // page stores, byte RAM, breaks and result word
    pmma_datapath #(
        .OFFSET_BITS    (OFFSET_BITS),
        .ADDRESS_BITS   (ADDRESS_BITS),
        .NUM_PHYS_PAGES (NUM_PHYS_PAGES),
        .MAX_PROCS      (MAX_PROCS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
